@@ rtl/spvg_pkg.sv @@
// Shared types, constants and tables for the star polygon vertex generator.
package spvg_pkg;

    localparam int PHASE_BITS_DEF      = 16;
    localparam int ROTATION_STAGES_DEF = 16;

    localparam int RADIUS_W = 16;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 9;
    localparam int POS_W    = 17;
    localparam int GAIN_W   = 24;
    localparam int ATAN_W   = 30;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [COUNT_W-1:0]  CORNER_RESET = 8'd5;
    localparam logic [RADIUS_W-1:0] INNER_RESET  = 16'd640;
    localparam logic [RADIUS_W-1:0] OUTER_RESET  = 16'd1600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER_COUNT = 2'd0,
        CFG_INNER_RADIUS = 2'd1,
        CFG_OUTER_RADIUS = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } t_quad;

    typedef struct packed {
        logic                valid;
        logic                bad;
        logic [RADIUS_W-1:0] radius;
    } t_item;

    function automatic logic [ATAN_W-1:0] atan_turn(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10679838;
            7:  v = 30'd5340245;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [GAIN_W-1:0] inv_gain(input int stages);
        logic [GAIN_W-1:0] v;
        case (stages)
            8:  v = 24'd10188117;
            9:  v = 24'd10188040;
            10: v = 24'd10188020;
            11: v = 24'd10188015;
            default: v = 24'd10188014;
        endcase
        return v;
    endfunction

    function automatic logic [POS_W-1:0] to_q124(input logic signed [35:0] v);
        logic signed [35:0] t;
        logic signed [19:0] r;
        t = v + 36'sd32768;
        r = t[35:16];
        if (r > 20'sd65535) begin
            return 17'h0FFFF;
        end else if (r < -20'sd65536) begin
            return 17'h10000;
        end
        return r[POS_W-1:0];
    endfunction

endpackage

@@ rtl/spvg_div.sv @@
// Pipelined restoring divider producing the vertex phase.
module spvg_div import spvg_pkg::*; #(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [INDEX_W-1:0]    i_point_index,
    input  logic [COUNT_W-1:0]    i_corner_count,
    input  logic [RADIUS_W-1:0]   i_radius,
    output t_item                 o_item,
    output logic [PHASE_BITS-1:0] o_phase
);

    localparam int W   = PHASE_BITS + INDEX_W;
    localparam int SPS = 4;
    localparam int DS  = (W + SPS - 1) / SPS;
    localparam int NW  = DS * SPS;
    localparam int MW  = COUNT_W + 1;

    logic [NW-1:0]       r_acc [0:DS];
    logic [MW-1:0]       r_rem [0:DS];
    logic [MW-1:0]       r_m   [0:DS];
    logic [RADIUS_W-1:0] r_rad [0:DS];
    logic                r_bad [0:DS];
    logic                r_v   [0:DS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]   <= i_valid;
            r_acc[0] <= NW'({i_point_index, {PHASE_BITS{1'b0}}}) + NW'(i_corner_count);
            r_rem[0] <= '0;
            r_m[0]   <= {i_corner_count, 1'b0};
            r_rad[0] <= i_radius;
            r_bad[0] <= (i_corner_count == '0);
        end
    end

    for (genvar s = 0; s < DS; s++) begin : g_stage
        logic [NW-1:0] n_acc;
        logic [MW-1:0] n_rem;
        logic [MW:0]   t;

        always_comb begin
            n_acc = r_acc[s];
            n_rem = r_rem[s];
            t     = '0;
            for (int k = 0; k < SPS; k++) begin
                t     = {n_rem, n_acc[NW-1]};
                n_acc = {n_acc[NW-2:0], 1'b0};
                if (t >= {1'b0, r_m[s]}) begin
                    t        = t - {1'b0, r_m[s]};
                    n_acc[0] = 1'b1;
                end
                n_rem = t[MW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1]   <= r_v[s];
                r_acc[s+1] <= n_acc;
                r_rem[s+1] <= n_rem;
                r_m[s+1]   <= r_m[s];
                r_rad[s+1] <= r_rad[s];
                r_bad[s+1] <= r_bad[s];
            end
        end
    end

    assign o_item.valid  = r_v[DS];
    assign o_item.bad    = r_bad[DS];
    assign o_item.radius = r_rad[DS];
    assign o_phase       = r_acc[DS][PHASE_BITS-1:0];

endmodule

@@ rtl/spvg_cordic.sv @@
// Gain-compensated CORDIC rotation pipeline with quadrant fold and output rounding.
module spvg_cordic import spvg_pkg::*; #(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_item                 i_item,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic                  o_valid,
    output logic [POS_W-1:0]      o_pos_x,
    output logic [POS_W-1:0]      o_pos_y,
    output logic                  o_bad_count
);

    localparam int RS = ROTATION_STAGES;
    localparam int XW = 36;
    localparam int ZW = ATAN_W + 3;
    localparam logic [GAIN_W-1:0] K = inv_gain(RS);

    logic signed [XW-1:0] r_x [0:RS];
    logic signed [XW-1:0] r_y [0:RS];
    logic signed [ZW-1:0] r_z [0:RS];
    t_quad                r_q [0:RS];
    logic                 r_bad [0:RS];
    logic                 r_v [0:RS];

    logic [RADIUS_W+GAIN_W-1:0] prod;
    logic [31:0]                turn;

    assign prod = RADIUS_W'(i_item.radius) * K;
    assign turn = 32'(i_phase) << (32 - PHASE_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]   <= i_item.valid;
            r_x[0]   <= signed'({4'b0, prod[RADIUS_W+GAIN_W-1:8]});
            r_y[0]   <= '0;
            r_z[0]   <= signed'({3'b0, turn[ATAN_W-1:0]});
            r_q[0]   <= t_quad'(turn[31:30]);
            r_bad[0] <= i_item.bad;
        end
    end

    for (genvar s = 0; s < RS; s++) begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;

        assign dx = r_y[s] >>> s;
        assign dy = r_x[s] >>> s;
        assign da = signed'(ZW'(atan_turn(s)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1]   <= r_v[s];
                r_q[s+1]   <= r_q[s];
                r_bad[s+1] <= r_bad[s];
                if (!r_z[s][ZW-1]) begin
                    r_x[s+1] <= r_x[s] - dx;
                    r_y[s+1] <= r_y[s] + dy;
                    r_z[s+1] <= r_z[s] - da;
                end else begin
                    r_x[s+1] <= r_x[s] + dx;
                    r_y[s+1] <= r_y[s] - dy;
                    r_z[s+1] <= r_z[s] + da;
                end
            end
        end
    end

    logic signed [XW-1:0] sn;
    logic signed [XW-1:0] cs;
    logic                 r_out_v;
    logic [POS_W-1:0]     r_pos_x;
    logic [POS_W-1:0]     r_pos_y;
    logic                 r_out_bad;

    always_comb begin
        case (r_q[RS])
            QUAD_I: begin
                sn = r_y[RS];
                cs = r_x[RS];
            end
            QUAD_II: begin
                sn = r_x[RS];
                cs = -r_y[RS];
            end
            QUAD_III: begin
                sn = -r_y[RS];
                cs = -r_x[RS];
            end
            default: begin
                sn = -r_x[RS];
                cs = r_y[RS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v   <= r_v[RS];
            r_out_bad <= r_bad[RS];
            r_pos_x   <= r_bad[RS] ? '0 : to_q124(sn);
            r_pos_y   <= r_bad[RS] ? '0 : to_q124(-cs);
        end
    end

    assign o_valid     = r_out_v;
    assign o_pos_x     = r_pos_x;
    assign o_pos_y     = r_pos_y;
    assign o_bad_count = r_out_bad;

endmodule

@@ rtl/star_polygon_vertex_generator_unit.sv @@
// Top level of the star polygon vertex generator: registers, divider and CORDIC.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  input    | i_in_valid / o_in_ready   | i_point_index
//  output   | o_out_valid / i_out_ready | o_pos_x, o_pos_y, o_bad_count
//  config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction per cycle unless the output stalls. Stages: divider input register,
// divider stages, CORDIC input register, rotation stages and output register.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// When a result waits and i_out_ready is low, the whole pipeline holds.
module star_polygon_vertex_generator_unit import spvg_pkg::*; #(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int ROTATION_STAGES = ROTATION_STAGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [INDEX_W-1:0]   i_point_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    output logic                 o_bad_count,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [COUNT_W-1:0]  r_corner_count;
    logic [RADIUS_W-1:0] r_inner_radius;
    logic [RADIUS_W-1:0] r_outer_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_count <= CORNER_RESET[COUNT_W-1:0];
            r_inner_radius <= INNER_RESET;
            r_outer_radius <= OUTER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CORNER_COUNT: r_corner_count <= i_cfg_data[COUNT_W-1:0];
                CFG_INNER_RADIUS: r_inner_radius <= i_cfg_data;
                CFG_OUTER_RADIUS: r_outer_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                  en;
    t_item                 div_item;
    logic [PHASE_BITS-1:0] div_phase;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    spvg_div #(
        .PHASE_BITS(PHASE_BITS)
    ) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_in_valid),
        .i_point_index (i_point_index),
        .i_corner_count(r_corner_count),
        .i_radius      (i_point_index[0] ? r_inner_radius : r_outer_radius),
        .o_item        (div_item),
        .o_phase       (div_phase)
    );

    spvg_cordic #(
        .PHASE_BITS     (PHASE_BITS),
        .ROTATION_STAGES(ROTATION_STAGES)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_item     (div_item),
        .i_phase    (div_phase),
        .o_valid    (o_out_valid),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_bad_count(o_bad_count)
    );

endmodule

@@ rtl/spvg_checker.sv @@
// Port-level checks for the star polygon vertex generator, bound to the top level.
module spvg_checker import spvg_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [POS_W-1:0]     o_pos_x,
    input logic [POS_W-1:0]     o_pos_y,
    input logic                 o_bad_count
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_bad_count))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_count |-> o_pos_x == '0 && o_pos_y == '0)
        else $error("nonzero coordinates with bad corner count");

endmodule

bind star_polygon_vertex_generator_unit spvg_checker u_spvg_checker (.*);
